// ===== sv/stids_pkg.sv =====
// Shared types, codes and key-order function for the sorted table core.
// Used by stids_cell and by sorted_table_insert_delete_search_core.
`default_nettype none

package stids_pkg;

	localparam int DEPTH_DEF        = 32;
	localparam int PAYLOAD_BITS_DEF = 32;
	localparam int KEY_W            = 32;
	localparam int DATA_W           = 32;

	typedef logic [1:0] cmd_t;
	typedef logic [1:0] status_t;
	typedef logic [1:0] key_type_t;

	localparam cmd_t CMD_INSERT = 2'd0;
	localparam cmd_t CMD_DELETE = 2'd1;
	localparam cmd_t CMD_SORTED = 2'd2;
	localparam cmd_t CMD_LINEAR = 2'd3;

	localparam status_t ST_DONE     = 2'd0;
	localparam status_t ST_NOTFOUND = 2'd1;
	localparam status_t ST_REJECT   = 2'd2;

	localparam key_type_t KT_S16 = 2'd0;
	localparam key_type_t KT_U16 = 2'd1;
	localparam key_type_t KT_S32 = 2'd2;
	localparam key_type_t KT_U32 = 2'd3;

	typedef enum logic [1:0] {
		SEL_HOLD,
		SEL_LOAD,
		SEL_BELOW,
		SEL_ABOVE
	} cell_sel_t;

	typedef struct packed {
		cell_sel_t sel;
		logic      cmp;
	} cell_ctl_t;

	// Map a key onto an unsigned value that orders as the selected key type.
	function automatic logic [KEY_W-1:0] order_value(input logic [KEY_W-1:0] k,
			input key_type_t kt);
		logic [KEY_W-1:0] v;
		case (kt)
			KT_S16:  v = {16'h0000, k[15:0] ^ 16'h8000};
			KT_U16:  v = {16'h0000, k[15:0]};
			KT_S32:  v = k ^ 32'h8000_0000;
			default: v = k;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== sv/stids_cell.sv =====
// One table slot: key and payload registers, neighbor shift mux and key compare.
// Depends on stids_pkg for the control struct and the key-order function.
`default_nettype none

module stids_cell #(
	parameter int PAY_W = 32
) (
	input  wire                        clk,
	input  stids_pkg::cell_ctl_t       ctl,
	input  wire [stids_pkg::KEY_W-1:0] search_ov,
	input  stids_pkg::key_type_t       key_type,
	input  wire [stids_pkg::KEY_W-1:0] new_key,
	input  wire [PAY_W-1:0]            new_pay,
	input  wire [stids_pkg::KEY_W-1:0] below_key,
	input  wire [PAY_W-1:0]            below_pay,
	input  wire [stids_pkg::KEY_W-1:0] above_key,
	input  wire [PAY_W-1:0]            above_pay,
	output logic [stids_pkg::KEY_W-1:0] key,
	output logic [PAY_W-1:0]            pay,
	output logic                        eq,
	output logic                        gt
);
	import stids_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] pay_q;
	logic             eq_q;
	logic             gt_q;
	logic [KEY_W-1:0] own_ov;

	assign own_ov = order_value(key_q, key_type);

	always_ff @(posedge clk) begin
		case (ctl.sel)
			SEL_LOAD: begin
				key_q <= new_key;
				pay_q <= new_pay;
			end
			SEL_BELOW: begin
				key_q <= below_key;
				pay_q <= below_pay;
			end
			SEL_ABOVE: begin
				key_q <= above_key;
				pay_q <= above_pay;
			end
			default: begin
				key_q <= key_q;
				pay_q <= pay_q;
			end
		endcase
	end

	// Capture compare flags against the search key when an item comes in.
	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			eq_q <= (search_ov == own_ov);
			gt_q <= (search_ov > own_ov);
		end
	end

	assign key = key_q;
	assign pay = pay_q;
	assign eq  = eq_q;
	assign gt  = gt_q;

endmodule

`default_nettype wire

// ===== sv/sorted_table_insert_delete_search_core.sv =====
// Top level of the sorted table core: cell row, command sequencer, result register.
// Depends on stids_pkg and stids_cell.
`default_nettype none

// Ordered table of DEPTH entries held in a row of cells, one entry per cell.
// Insert loads the new entry at its position and moves the cells above it to
// their lower neighbor's entry, and delete moves cells to their upper
// neighbor's entry, at the edge that accepts the item; the result shows in
// the next cycle. A search item first latches compare flags in every cell in
// its accept cycle. Sorted find then probes one midpoint of those flags per
// cycle until it hits or the window is empty. A hit skips the final
// empty-window check and goes to the entry fetch. Linear find takes a
// first-match scan of the flags in S_LIN; a hit adds the entry fetch in
// S_FETCH before S_OUT. One item is in work at a time; the next item is
// taken in the cycle that the previous result leaves. key_type should be
// written only while idle.
module sorted_table_insert_delete_search_core #(
	parameter int DEPTH        = stids_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BITS = stids_pkg::PAYLOAD_BITS_DEF,
	parameter int CNT_W        = $clog2(DEPTH + 1)
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_wen,
	input  stids_pkg::key_type_t        cfg_wdata,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  stids_pkg::cmd_t             command,
	input  wire [CNT_W-1:0]             position,
	input  wire [stids_pkg::KEY_W-1:0]  key,
	input  wire [stids_pkg::DATA_W-1:0] payload,
	output logic                        out_valid,
	input  wire                         out_stall,
	output stids_pkg::status_t          status,
	output logic [CNT_W-1:0]            index,
	output logic [stids_pkg::KEY_W-1:0] found_key,
	output logic [stids_pkg::DATA_W-1:0] found_payload,
	output logic [CNT_W-1:0]            entry_count
);
	import stids_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int PW    = (PAYLOAD_BITS < DATA_W) ? PAYLOAD_BITS : DATA_W;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SRCH  = 3'd1;
	localparam logic [2:0] S_LIN   = 3'd2;
	localparam logic [2:0] S_FETCH = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] count_q;
	key_type_t        key_type_q;

	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hi_q;
	logic [IDX_W-1:0] fidx_q;
	status_t          status_q;
	logic [CNT_W-1:0] index_q;
	logic [KEY_W-1:0] fkey_q;
	logic [DATA_W-1:0] fpay_q;

	logic in_acc;
	logic out_acc;
	logic ins_go;
	logic del_go;
	logic [CNT_W-1:0] ins_pos;
	logic [KEY_W-1:0] search_ov;
	logic [PW-1:0]    new_pay;

	logic [KEY_W-1:0] ent_key [DEPTH];
	logic [PW-1:0]    ent_pay [DEPTH];
	logic [DEPTH-1:0] eq_vec;
	logic [DEPTH-1:0] gt_vec;

	logic [CNT_W:0]   mid_sum;
	logic [CNT_W-1:0] mid;
	logic [IDX_W-1:0] mid_i;
	logic             lin_hit;
	logic [IDX_W-1:0] lin_idx;

	assign out_valid = (state_q == S_OUT);
	assign out_acc   = out_valid && !out_stall;
	assign in_stall  = !((state_q == S_IDLE) || out_acc);
	assign in_acc    = in_valid && !in_stall;

	assign ins_go  = in_acc && (command == CMD_INSERT) && (count_q != DEPTH_C);
	assign del_go  = in_acc && (command == CMD_DELETE) && (position < count_q);
	assign ins_pos = (position > count_q) ? count_q : position;

	assign search_ov = order_value(key, key_type_q);
	assign new_pay   = payload[PW-1:0];

	// Cell row: each cell picks its own next entry from the broadcast command.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] I_C  = CNT_W'(i);
		localparam logic [CNT_W-1:0] I1_C = CNT_W'(i + 1);
		localparam int BI = (i == 0) ? 0 : i - 1;
		localparam int AI = (i == DEPTH - 1) ? i : i + 1;
		cell_ctl_t ctl;

		always_comb begin
			ctl.cmp = in_acc;
			if (ins_go && (I_C == ins_pos)) begin
				ctl.sel = SEL_LOAD;
			end else if (ins_go && (I_C > ins_pos) && (I_C <= count_q)) begin
				ctl.sel = SEL_BELOW;
			end else if (del_go && (I_C >= position) && (I1_C < count_q)) begin
				ctl.sel = SEL_ABOVE;
			end else begin
				ctl.sel = SEL_HOLD;
			end
		end

		stids_cell #(
			.PAY_W(PW)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.search_ov(search_ov),
			.key_type (key_type_q),
			.new_key  (key),
			.new_pay  (new_pay),
			.below_key(ent_key[BI]),
			.below_pay(ent_pay[BI]),
			.above_key(ent_key[AI]),
			.above_pay(ent_pay[AI]),
			.key      (ent_key[i]),
			.pay      (ent_pay[i]),
			.eq       (eq_vec[i]),
			.gt       (gt_vec[i])
		);
	end

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CNT_W:1];
	assign mid_i   = mid[IDX_W-1:0];

	// First match below count; later hits are overridden by earlier ones.
	always_comb begin
		lin_hit = 1'b0;
		lin_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (eq_vec[i] && (CNT_W'(i) < count_q)) begin
				lin_hit = 1'b1;
				lin_idx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			key_type_q <= KT_U32;
		end else begin
			if (cfg_wen) begin
				key_type_q <= cfg_wdata;
			end
			if (ins_go) begin
				count_q <= count_q + 1'b1;
			end else if (del_go) begin
				count_q <= count_q - 1'b1;
			end
			if (in_acc) begin
				case (command)
					CMD_SORTED: state_q <= S_SRCH;
					CMD_LINEAR: state_q <= S_LIN;
					default:    state_q <= S_OUT;
				endcase
			end else begin
				case (state_q)
					S_SRCH: begin
						if (lo_q >= hi_q) begin
							state_q <= S_OUT;
						end else if (eq_vec[mid_i]) begin
							state_q <= S_FETCH;
						end
					end
					S_LIN:   state_q <= lin_hit ? S_FETCH : S_OUT;
					S_FETCH: state_q <= S_OUT;
					S_OUT: begin
						if (out_acc) begin
							state_q <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			lo_q   <= '0;
			hi_q   <= count_q;
			fkey_q <= '0;
			fpay_q <= '0;
			case (command)
				CMD_INSERT: begin
					status_q <= ins_go ? ST_DONE : ST_REJECT;
					index_q  <= ins_go ? ins_pos : '0;
				end
				CMD_DELETE: begin
					status_q <= del_go ? ST_DONE : ST_REJECT;
					index_q  <= del_go ? position : '0;
				end
				default: begin
					status_q <= ST_NOTFOUND;
					index_q  <= '0;
				end
			endcase
		end else begin
			case (state_q)
				S_SRCH: begin
					if (lo_q >= hi_q) begin
						status_q <= ST_NOTFOUND;
						index_q  <= hi_q;
					end else if (eq_vec[mid_i]) begin
						fidx_q   <= mid_i;
						status_q <= ST_DONE;
						index_q  <= mid;
					end else if (gt_vec[mid_i]) begin
						lo_q <= mid + 1'b1;
					end else begin
						hi_q <= mid;
					end
				end
				S_LIN: begin
					fidx_q   <= lin_idx;
					status_q <= lin_hit ? ST_DONE : ST_NOTFOUND;
					index_q  <= lin_hit ? CNT_W'(lin_idx) : count_q;
				end
				S_FETCH: begin
					fkey_q <= ent_key[fidx_q];
					fpay_q <= DATA_W'(ent_pay[fidx_q]);
				end
				default: begin
					fidx_q <= fidx_q;
				end
			endcase
		end
	end

	assign status        = status_q;
	assign index         = index_q;
	assign found_key     = fkey_q;
	assign found_payload = fpay_q;
	assign entry_count   = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count above depth");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (command == CMD_INSERT) && (count_q != DEPTH_C))
		|=> (count_q == $past(count_q) + 1'b1))
		else $error("accepted insert did not grow the table");

	a_search_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH) |-> ((lo_q <= hi_q) && (hi_q <= count_q)))
		else $error("search window outside the table");

	a_no_result_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH) |=> !$past(out_valid))
		else $error("result shown while a search is in work");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking bench for sorted_table_insert_delete_search_core: directed, fill/drain
// and random phases per key type, with a shadow table predicting every reply.
// Depends on stids_pkg and the core RTL.

module tb_top;
	import stids_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		status_t         status;
		logic [CW-1:0]   index;
		logic [KEY_W-1:0]  fkey;
		logic [DATA_W-1:0] fpay;
		logic [CW-1:0]   count;
	} reply_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_COIN,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	key_type_t cfg_wdata = KT_U32;
	logic in_valid = 1'b0;
	logic in_stall;
	cmd_t command = CMD_INSERT;
	logic [CW-1:0] position = '0;
	logic [KEY_W-1:0] key = '0;
	logic [DATA_W-1:0] payload = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	status_t status;
	logic [CW-1:0] index;
	logic [KEY_W-1:0] found_key;
	logic [DATA_W-1:0] found_payload;
	logic [CW-1:0] entry_count;

	// shadow of the table
	logic [KEY_W-1:0] tbl_key [DEPTH];
	logic [DATA_W-1:0] tbl_pay [DEPTH];
	int tbl_count = 0;
	key_type_t tbl_kt = KT_U32;

	reply_t reply_q [$];
	int error_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	logic in_hold = 1'b0;
	stall_mode_t stall_mode = STALL_NONE;
	int stall_left = 0;

	sorted_table_insert_delete_search_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.position     (position),
		.key          (key),
		.payload      (payload),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.index        (index),
		.found_key    (found_key),
		.found_payload(found_payload),
		.entry_count  (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Rank a key so that plain unsigned order matches the selected key type.
	function automatic logic [31:0] key_rank(logic [31:0] k, key_type_t kt);
		logic [31:0] r;
		if (kt == KT_S32 || kt == KT_U32)
			r = k;
		else
			r = {16'h0000, k[15:0]};
		if (kt == KT_S16)
			r[15] = ~r[15];
		else if (kt == KT_S32)
			r[31] = ~r[31];
		return r;
	endfunction

	task automatic predict_reply(input cmd_t c, input logic [CW-1:0] p,
			input logic [KEY_W-1:0] k, input logic [DATA_W-1:0] d, output reply_t r);
		int lo, hi, mid, i;
		logic [31:0] want_rank;
		logic hit;
		r.status = ST_DONE;
		r.index = '0;
		r.fkey = '0;
		r.fpay = '0;
		want_rank = key_rank(k, tbl_kt);
		hit = 1'b0;
		case (c)
		CMD_INSERT: begin
			if (tbl_count == DEPTH) begin
				r.status = ST_REJECT;
			end else begin
				lo = (p > tbl_count) ? tbl_count : int'(p);
				for (i = tbl_count; i > lo; i--) begin
					tbl_key[i] = tbl_key[i-1];
					tbl_pay[i] = tbl_pay[i-1];
				end
				tbl_key[lo] = k;
				tbl_pay[lo] = d;
				tbl_count++;
				r.index = CW'(lo);
			end
		end
		CMD_DELETE: begin
			if (p >= tbl_count) begin
				r.status = ST_REJECT;
			end else begin
				for (i = int'(p); i + 1 < tbl_count; i++) begin
					tbl_key[i] = tbl_key[i+1];
					tbl_pay[i] = tbl_pay[i+1];
				end
				tbl_count--;
				r.index = p;
			end
		end
		CMD_SORTED: begin
			lo = 0;
			hi = tbl_count;
			mid = 0;
			while (lo < hi && !hit) begin
				mid = (lo + hi) / 2;
				if (want_rank > key_rank(tbl_key[mid], tbl_kt))
					lo = mid + 1;
				else if (want_rank < key_rank(tbl_key[mid], tbl_kt))
					hi = mid;
				else
					hit = 1'b1;
			end
			if (hit) begin
				r.index = CW'(mid);
				r.fkey = tbl_key[mid];
				r.fpay = tbl_pay[mid];
			end else begin
				r.status = ST_NOTFOUND;
				r.index = CW'(hi);
			end
		end
		CMD_LINEAR: begin
			mid = 0;
			for (i = 0; i < tbl_count; i++) begin
				if (!hit && key_rank(tbl_key[i], tbl_kt) == want_rank) begin
					hit = 1'b1;
					mid = i;
				end
			end
			if (hit) begin
				r.index = CW'(mid);
				r.fkey = tbl_key[mid];
				r.fpay = tbl_pay[mid];
			end else begin
				r.status = ST_NOTFOUND;
				r.index = CW'(tbl_count);
			end
		end
		endcase
		r.count = CW'(tbl_count);
	endtask

	task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : check_replies
		reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (reply_q.size() == 0) begin
				$display("%0t: unexpected reply: expected none, actual status %h index %h",
					$time, status, index);
				error_count++;
			end else begin
				want = reply_q.pop_front();
				report_field("status", 32'(want.status), 32'(status));
				report_field("index", 32'(want.index), 32'(index));
				report_field("found_key", want.fkey, found_key);
				report_field("found_payload", want.fpay, found_payload);
				report_field("entry_count", 32'(want.count), 32'(entry_count));
			end
		end
	end

	// Receiver back-pressure: switch to a randomly picked stall style whenever the countdown runs out.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(32, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
		STALL_NONE:     out_stall <= 1'b0;
		STALL_COIN:     out_stall <= ($urandom_range(0, 1) == 1);
		STALL_PERIODIC: out_stall <= (stall_left[1:0] == 2'b00);
		STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	task automatic send_command(cmd_t c, logic [CW-1:0] p, logic [KEY_W-1:0] k,
			logic [DATA_W-1:0] d);
		reply_t want;
		if (burst_left == 0) begin
			if (in_hold) begin
				in_valid <= 1'b0;
				in_hold = 1'b0;
			end
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		command <= c;
		position <= p;
		key <= k;
		payload <= d;
		in_valid <= 1'b1;
		in_hold = 1'b1;
		do @(posedge clk); while (in_stall);
		predict_reply(c, p, k, d, want);
		reply_q.push_back(want);
		burst_left--;
	endtask

	task automatic release_input();
		if (in_hold) begin
			in_valid <= 1'b0;
			in_hold = 1'b0;
		end
		burst_left = 0;
	endtask

	task automatic wait_drained();
		while (reply_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_key_type(key_type_t kt);
		release_input();
		wait_drained();
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= kt;
		@(posedge clk);
		cfg_wen <= 1'b0;
		tbl_kt = kt;
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		logic [KEY_W-1:0] k;
		case ($urandom_range(0, 3))
		0: k = $urandom;
		1: begin
			case ($urandom_range(0, 7))
			0: k = 32'h0000_0000;
			1: k = 32'hFFFF_FFFF;
			2: k = 32'h8000_0000;
			3: k = 32'h7FFF_FFFF;
			4: k = 32'h0000_8000;
			5: k = 32'h0000_7FFF;
			6: k = 32'hFFFF_0000;
			default: k = 32'h0000_FFFF;
			endcase
		end
		2: begin
			// narrow pool: forces duplicates and low-half aliases
			k[31:16] = ($urandom_range(0, 1) == 1) ? 16'h8001 : 16'h0000;
			k[15:0] = 16'($urandom_range(0, 7)) ^ (($urandom_range(0, 1) == 1) ? 16'h8000 : 16'h0);
		end
		default: begin
			if (tbl_count > 0)
				k = tbl_key[$urandom_range(0, tbl_count - 1)] + 32'($urandom_range(0, 2)) - 1;
			else
				k = $urandom;
		end
		endcase
		return k;
	endfunction

	function automatic logic [KEY_W-1:0] search_key();
		logic [KEY_W-1:0] k;
		if (tbl_count > 0 && $urandom_range(0, 2) != 0) begin
			k = tbl_key[$urandom_range(0, tbl_count - 1)];
			if ($urandom_range(0, 3) == 0)
				k[31:16] = 16'($urandom);
		end else begin
			k = pick_key();
		end
		return k;
	endfunction

	// Position that keeps the table ordered, before or after equal keys.
	function automatic logic [CW-1:0] sorted_slot(logic [KEY_W-1:0] k, logic after_equal);
		int i;
		logic [31:0] kr;
		kr = key_rank(k, tbl_kt);
		for (i = 0; i < tbl_count; i++) begin
			if (after_equal ? key_rank(tbl_key[i], tbl_kt) > kr
					: key_rank(tbl_key[i], tbl_kt) >= kr)
				break;
		end
		return CW'(i);
	endfunction

	task automatic test_directed();
		send_command(CMD_SORTED, '0, 32'h0, 32'h0);
		send_command(CMD_LINEAR, '0, 32'hFFFF_FFFF, 32'h0);
		send_command(CMD_DELETE, '0, 32'h0, 32'h0);
		send_command(CMD_INSERT, CW'(63), 32'h8000_0000, 32'hFFFF_FFFF);
		send_command(CMD_INSERT, '0, 32'h0000_0000, 32'h0000_0000);
		send_command(CMD_INSERT, CW'(2), 32'hFFFF_FFFF, 32'hA5A5_A5A5);
		send_command(CMD_INSERT, CW'(33), 32'h7FFF_FFFF, 32'h5A5A_5A5A);
		send_command(CMD_SORTED, CW'(63), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_command(CMD_SORTED, '0, 32'h0000_0000, 32'h0);
		send_command(CMD_SORTED, '0, 32'h0000_0001, 32'h0);
		send_command(CMD_LINEAR, '0, 32'h7FFF_FFFF, 32'h0);
		send_command(CMD_LINEAR, '0, 32'h1234_5678, 32'h0);
		send_command(CMD_DELETE, CW'(63), 32'h0, 32'h0);
		send_command(CMD_DELETE, CW'(tbl_count), 32'h0, 32'h0);
		send_command(CMD_DELETE, CW'(tbl_count - 1), 32'h0, 32'h0);
		send_command(CMD_DELETE, '0, 32'h0, 32'h0);
		send_command(CMD_LINEAR, CW'(32), 32'h8000_0000, 32'h0);
	endtask

	task automatic test_fill_and_drain();
		logic [KEY_W-1:0] k;
		int i;
		set_key_type(KT_S32);
		while (tbl_count < DEPTH) begin
			k = pick_key();
			send_command(CMD_INSERT, sorted_slot(k, ($urandom_range(0, 1) == 1)), k, $urandom);
		end
		// full table: every insert bounces
		send_command(CMD_INSERT, '0, 32'h1, 32'h1);
		send_command(CMD_INSERT, CW'(DEPTH), 32'h2, 32'h2);
		send_command(CMD_INSERT, CW'(63), 32'h3, 32'h3);
		for (i = 0; i < 4; i++) begin
			send_command(CMD_SORTED, CW'($urandom_range(0, 63)), search_key(), $urandom);
			send_command(CMD_LINEAR, CW'($urandom_range(0, 63)), search_key(), $urandom);
		end
		send_command(CMD_DELETE, CW'(DEPTH), 32'h0, 32'h0);
		send_command(CMD_DELETE, CW'(63), 32'h0, 32'h0);
		while (tbl_count > 0)
			send_command(CMD_DELETE, CW'($urandom_range(0, tbl_count - 1)), $urandom, $urandom);
		send_command(CMD_DELETE, '0, 32'h0, 32'h0);
		send_command(CMD_SORTED, '0, $urandom, 32'h0);
	endtask

	task automatic test_random_phase(key_type_t kt, int n_items);
		int i, target;
		logic [KEY_W-1:0] k;
		logic grow;
		set_key_type(kt);
		target = $urandom_range(0, DEPTH);
		for (i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 39) == 0)
				target = $urandom_range(0, DEPTH);
			case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				grow = (tbl_count == target) ? ($urandom_range(0, 1) == 1) : (tbl_count < target);
				if (grow) begin
					k = pick_key();
					if ($urandom_range(0, 7) == 0)
						send_command(CMD_INSERT, CW'($urandom_range(0, 63)), k, $urandom);
					else
						send_command(CMD_INSERT,
							sorted_slot(k, ($urandom_range(0, 1) == 1)), k, $urandom);
				end else if (tbl_count > 0) begin
					send_command(CMD_DELETE, CW'($urandom_range(0, tbl_count - 1)), $urandom,
						$urandom);
				end else begin
					send_command(CMD_DELETE, CW'($urandom_range(0, 63)), $urandom, $urandom);
				end
			end
			4, 5, 6: send_command(CMD_SORTED, CW'($urandom_range(0, 63)), search_key(), $urandom);
			7, 8:    send_command(CMD_LINEAR, CW'($urandom_range(0, 63)), search_key(), $urandom);
			default: begin
				// noise: any command, any position, any key
				send_command(cmd_t'($urandom_range(0, 3)), CW'($urandom_range(0, 63)),
					$urandom, $urandom);
			end
			endcase
		end
	endtask

	initial begin
		key_type_t phase_kt [8];
		int p;
		phase_kt = '{KT_U16, KT_S16, KT_U32, KT_S32, KT_S16, KT_U16, KT_U32, KT_S32};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_fill_and_drain();
		for (p = 0; p < 8; p++)
			test_random_phase(phase_kt[p], 195);
		release_input();
		wait_drained();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
